// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level filter unit to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/ppcf_pkg.sv =====
// Shared constants for the periodic pair cutoff filter.
`default_nettype none

package ppcf_pkg;

  localparam int AXIS_COUNT   = 3;
  localparam int OFFSET_COUNT = 3;
  localparam int IMAGE_COUNT  = 27;
  localparam int IMAGE_BITS   = 5;
  localparam int OFS_BITS     = 2;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // Candidate slot per axis: image offset -1, 0, +1
  localparam int OFFSET_NEG  = 0;
  localparam int OFFSET_ZERO = 1;
  localparam int OFFSET_POS  = 2;

  localparam int REG_INDEX_BITS = 2;
  localparam logic [REG_INDEX_BITS-1:0] REG_BOX_X     = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_BOX_Y     = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_BOX_Z     = 2'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_CUTOFF_SQ = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/ppcf_if.sv =====
// Request channels of the filter: particle pairs in, image hits out.
`default_nettype none

interface ppcf_pair_if #(
  parameter int INDEX_BITS    = 16,
  parameter int POSITION_BITS = 24
);
  logic                     valid;
  logic                     ready;
  logic [INDEX_BITS-1:0]    first_index;
  logic [INDEX_BITS-1:0]    second_index;
  logic [POSITION_BITS-1:0] first_x;
  logic [POSITION_BITS-1:0] first_y;
  logic [POSITION_BITS-1:0] first_z;
  logic [POSITION_BITS-1:0] second_x;
  logic [POSITION_BITS-1:0] second_y;
  logic [POSITION_BITS-1:0] second_z;

  modport source (
    output valid, first_index, second_index,
    output first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, first_index, second_index,
    input  first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

interface ppcf_hit_if #(
  parameter int INDEX_BITS    = 16,
  parameter int POSITION_BITS = 24
);
  logic                                 valid;
  logic                                 ready;
  logic signed [POSITION_BITS+1:0]      sep_x;
  logic signed [POSITION_BITS+1:0]      sep_y;
  logic signed [POSITION_BITS+1:0]      sep_z;
  logic [INDEX_BITS-1:0]                pair_first;
  logic [INDEX_BITS-1:0]                pair_second;
  logic [ppcf_pkg::IMAGE_BITS-1:0]      image_number;
  logic                                 last;

  modport source (
    output valid, sep_x, sep_y, sep_z, pair_first, pair_second, image_number, last,
    input  ready
  );
  modport sink (
    input  valid, sep_x, sep_y, sep_z, pair_first, pair_second, image_number, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ppcf_sep_stage.sv =====
// Stage 1: per-axis base separation and the three image candidates.
`default_nettype none

module ppcf_sep_stage #(
  parameter int INDEX_BITS    = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  ppcf_pair_if.sink pairs,
  input  wire logic [POSITION_BITS-1:0] box_x,
  input  wire logic [POSITION_BITS-1:0] box_y,
  input  wire logic [POSITION_BITS-1:0] box_z,
  output logic dn_valid,
  input  wire logic dn_ready,
  output logic [INDEX_BITS-1:0] first_index,
  output logic [INDEX_BITS-1:0] second_index,
  output logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][POSITION_BITS+1:0] sep
);

  localparam int SEP_W = POSITION_BITS + 2;

  logic [ppcf_pkg::AXIS_COUNT-1:0][POSITION_BITS-1:0] first_pos;
  logic [ppcf_pkg::AXIS_COUNT-1:0][POSITION_BITS-1:0] second_pos;
  logic [ppcf_pkg::AXIS_COUNT-1:0][POSITION_BITS-1:0] box_len;
  logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][SEP_W-1:0] sep_next;
  logic up_ready;

  assign first_pos[ppcf_pkg::AXIS_X]  = pairs.first_x;
  assign first_pos[ppcf_pkg::AXIS_Y]  = pairs.first_y;
  assign first_pos[ppcf_pkg::AXIS_Z]  = pairs.first_z;
  assign second_pos[ppcf_pkg::AXIS_X] = pairs.second_x;
  assign second_pos[ppcf_pkg::AXIS_Y] = pairs.second_y;
  assign second_pos[ppcf_pkg::AXIS_Z] = pairs.second_z;
  assign box_len[ppcf_pkg::AXIS_X]    = box_x;
  assign box_len[ppcf_pkg::AXIS_Y]    = box_y;
  assign box_len[ppcf_pkg::AXIS_Z]    = box_z;

  // Two's complement modulo 2^SEP_W; every value fits exactly.
  always_comb begin
    logic [SEP_W-1:0] base;
    for (int a = 0; a < ppcf_pkg::AXIS_COUNT; a++) begin
      base = SEP_W'(first_pos[a]) - SEP_W'(second_pos[a]);
      sep_next[a][ppcf_pkg::OFFSET_NEG]  = base + SEP_W'(box_len[a]);
      sep_next[a][ppcf_pkg::OFFSET_ZERO] = base;
      sep_next[a][ppcf_pkg::OFFSET_POS]  = base - SEP_W'(box_len[a]);
    end
  end

  assign up_ready    = !dn_valid || dn_ready;
  assign pairs.ready = up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= pairs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && pairs.valid) begin
      first_index  <= pairs.first_index;
      second_index <= pairs.second_index;
      sep          <= sep_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppcf_square_stage.sv =====
// Stage 2: squares of the nine per-axis candidates.
`default_nettype none

module ppcf_square_stage #(
  parameter int INDEX_BITS    = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire logic [INDEX_BITS-1:0] up_first_index,
  input  wire logic [INDEX_BITS-1:0] up_second_index,
  input  wire logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][POSITION_BITS+1:0]
    up_sep,
  output logic dn_valid,
  input  wire logic dn_ready,
  output logic [INDEX_BITS-1:0] first_index,
  output logic [INDEX_BITS-1:0] second_index,
  output logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][POSITION_BITS+1:0] sep,
  output logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][2*POSITION_BITS+1:0] sq
);

  localparam int SEP_W = POSITION_BITS + 2;
  localparam int MAG_W = POSITION_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;

  logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][SQ_W-1:0] sq_next;

  // Magnitude never reaches 2^MAG_W, so the top bit of the negation is dropped.
  always_comb begin
    logic [SEP_W-1:0] mag_full;
    logic [MAG_W-1:0] mag;
    for (int a = 0; a < ppcf_pkg::AXIS_COUNT; a++) begin
      for (int o = 0; o < ppcf_pkg::OFFSET_COUNT; o++) begin
        mag_full = up_sep[a][o][SEP_W-1] ? (~up_sep[a][o] + SEP_W'(1)) : up_sep[a][o];
        mag      = mag_full[MAG_W-1:0];
        sq_next[a][o] = SQ_W'(mag) * SQ_W'(mag);
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      first_index  <= up_first_index;
      second_index <= up_second_index;
      sep          <= up_sep;
      sq           <= sq_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppcf_cutoff_stage.sv =====
// Stage 3: squared length of all 27 images and the cutoff test.
`default_nettype none

module ppcf_cutoff_stage #(
  parameter int INDEX_BITS    = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [2*POSITION_BITS+3:0] cutoff_sq,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire logic [INDEX_BITS-1:0] up_first_index,
  input  wire logic [INDEX_BITS-1:0] up_second_index,
  input  wire logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][POSITION_BITS+1:0]
    up_sep,
  input  wire logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][2*POSITION_BITS+1:0]
    up_sq,
  output logic dn_valid,
  input  wire logic dn_ready,
  output logic [INDEX_BITS-1:0] first_index,
  output logic [INDEX_BITS-1:0] second_index,
  output logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][POSITION_BITS+1:0] sep,
  output logic [ppcf_pkg::IMAGE_COUNT-1:0] hit_mask
);

  localparam int SUM_W = 2 * POSITION_BITS + 4;
  localparam int OC    = ppcf_pkg::OFFSET_COUNT;

  logic [ppcf_pkg::IMAGE_COUNT-1:0] hit_next;

  // Image code = dx*9 + dy*3 + dz with each offset slot in 0..2.
  for (genvar dx = 0; dx < OC; dx++) begin : g_dx
    for (genvar dy = 0; dy < OC; dy++) begin : g_dy
      for (genvar dz = 0; dz < OC; dz++) begin : g_dz
        logic [SUM_W-1:0] len2;
        assign len2 = SUM_W'(up_sq[ppcf_pkg::AXIS_X][dx])
                    + SUM_W'(up_sq[ppcf_pkg::AXIS_Y][dy])
                    + SUM_W'(up_sq[ppcf_pkg::AXIS_Z][dz]);
        assign hit_next[dx*OC*OC + dy*OC + dz] = len2 < cutoff_sq;
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      first_index  <= up_first_index;
      second_index <= up_second_index;
      sep          <= up_sep;
      hit_mask     <= hit_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppcf_serializer.sv =====
// Stage 4: walk the hit mask lowest image first into the output register.
`default_nettype none

module ppcf_serializer #(
  parameter int INDEX_BITS    = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire logic [INDEX_BITS-1:0] up_first_index,
  input  wire logic [INDEX_BITS-1:0] up_second_index,
  input  wire logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][POSITION_BITS+1:0]
    up_sep,
  input  wire logic [ppcf_pkg::IMAGE_COUNT-1:0] up_hit_mask,
  ppcf_hit_if.source hits
);

  localparam int OC = ppcf_pkg::OFFSET_COUNT;

  logic [ppcf_pkg::IMAGE_COUNT-1:0] mask;
  logic [ppcf_pkg::IMAGE_COUNT-1:0] rest;
  logic [INDEX_BITS-1:0] first_index;
  logic [INDEX_BITS-1:0] second_index;
  logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFFSET_COUNT-1:0][POSITION_BITS+1:0] sep;
  logic [ppcf_pkg::IMAGE_BITS-1:0] pick;
  logic [ppcf_pkg::AXIS_COUNT-1:0][ppcf_pkg::OFS_BITS-1:0] pick_ofs;
  logic busy;
  logic out_take;
  logic emit;

  // Priority pick: scan high to low so the lowest set image wins.
  always_comb begin
    pick     = '0;
    pick_ofs = '0;
    for (int dx = OC - 1; dx >= 0; dx--) begin
      for (int dy = OC - 1; dy >= 0; dy--) begin
        for (int dz = OC - 1; dz >= 0; dz--) begin
          if (mask[dx*OC*OC + dy*OC + dz]) begin
            pick = ppcf_pkg::IMAGE_BITS'(dx*OC*OC + dy*OC + dz);
            pick_ofs[ppcf_pkg::AXIS_X] = ppcf_pkg::OFS_BITS'(dx);
            pick_ofs[ppcf_pkg::AXIS_Y] = ppcf_pkg::OFS_BITS'(dy);
            pick_ofs[ppcf_pkg::AXIS_Z] = ppcf_pkg::OFS_BITS'(dz);
          end
        end
      end
    end
  end

  assign rest     = mask & (mask - ppcf_pkg::IMAGE_COUNT'(1));
  assign busy     = |mask;
  assign out_take = !hits.valid || hits.ready;
  assign emit     = busy && out_take;
  assign up_ready = !busy || (out_take && (rest == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (up_ready) begin
      mask <= up_valid ? up_hit_mask : '0;
    end else if (emit) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      first_index  <= up_first_index;
      second_index <= up_second_index;
      sep          <= up_sep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits.valid <= 1'b0;
    end else if (out_take) begin
      hits.valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hits.sep_x        <= sep[ppcf_pkg::AXIS_X][pick_ofs[ppcf_pkg::AXIS_X]];
      hits.sep_y        <= sep[ppcf_pkg::AXIS_Y][pick_ofs[ppcf_pkg::AXIS_Y]];
      hits.sep_z        <= sep[ppcf_pkg::AXIS_Z][pick_ofs[ppcf_pkg::AXIS_Z]];
      hits.pair_first   <= first_index;
      hits.pair_second  <= second_index;
      hits.image_number <= pick;
      hits.last         <= (rest == '0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/periodic_pair_cutoff_filter_unit.sv =====
// Top level of the periodic pair cutoff filter: config registers and four-stage pipeline.
//
// Usage:
//   pairs  - request channel carrying one particle pair (two indices, two Q8.16
//            positions). A request is taken on a clock edge with valid and ready high.
//   hits   - request channel carrying one image within the cutoff: separation
//            (signed Q9.16 per axis), echoed indices, image code 0..26 and last.
//   cfg_*  - write port for box_x, box_y, box_z (index 0..2) and cutoff_sq (3).
//            Write only while no pair is in flight.
// A pair passes the stage 1 to 3 registers and the serializer mask before its first hit.
// Throughput: one pair per cycle while pairs give at most one hit and hits.ready
//   stays high; a pair with more hits holds the serializer until its last hit is
//   emitted. The 27 squared lengths come from nine parallel per-axis squares;
//   the hit serializer sets the rate.
// Pairs with no hit pass through and produce nothing.
// Reset (rst, synchronous) clears the config registers to zero and empties the pipe.
// When hits.ready is low the output register holds its request, the serializer
//   holds its pair, and back-pressure fills the stages before pairs.ready drops.
`default_nettype none
`include "assert_macros.svh"

module periodic_pair_cutoff_filter_unit #(
  parameter int INDEX_BITS    = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  ppcf_pair_if.sink  pairs,
  ppcf_hit_if.source hits,
  input  wire logic                                cfg_we,
  input  wire logic [ppcf_pkg::REG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [2*POSITION_BITS+3:0]          cfg_data
);

  localparam int SEP_W = POSITION_BITS + 2;
  localparam int SQ_W  = 2 * POSITION_BITS + 2;
  localparam int SUM_W = 2 * POSITION_BITS + 4;
  localparam int AC    = ppcf_pkg::AXIS_COUNT;
  localparam int OC    = ppcf_pkg::OFFSET_COUNT;

  // Configuration registers
  logic [POSITION_BITS-1:0] box_x;
  logic [POSITION_BITS-1:0] box_y;
  logic [POSITION_BITS-1:0] box_z;
  logic [SUM_W-1:0]         cutoff_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x     <= '0;
      box_y     <= '0;
      box_z     <= '0;
      cutoff_sq <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppcf_pkg::REG_BOX_X:     box_x     <= cfg_data[POSITION_BITS-1:0];
        ppcf_pkg::REG_BOX_Y:     box_y     <= cfg_data[POSITION_BITS-1:0];
        ppcf_pkg::REG_BOX_Z:     box_z     <= cfg_data[POSITION_BITS-1:0];
        ppcf_pkg::REG_CUTOFF_SQ: cutoff_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: separations of the three candidates per axis
  logic s1_valid;
  logic s1_ready;
  logic [INDEX_BITS-1:0] s1_first_index;
  logic [INDEX_BITS-1:0] s1_second_index;
  logic [AC-1:0][OC-1:0][SEP_W-1:0] s1_sep;

  ppcf_sep_stage #(
    .INDEX_BITS   (INDEX_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_sep (
    .clk         (clk),
    .rst         (rst),
    .pairs       (pairs),
    .box_x       (box_x),
    .box_y       (box_y),
    .box_z       (box_z),
    .dn_valid    (s1_valid),
    .dn_ready    (s1_ready),
    .first_index (s1_first_index),
    .second_index(s1_second_index),
    .sep         (s1_sep)
  );

  // Stage 2: nine squares
  logic s2_valid;
  logic s2_ready;
  logic [INDEX_BITS-1:0] s2_first_index;
  logic [INDEX_BITS-1:0] s2_second_index;
  logic [AC-1:0][OC-1:0][SEP_W-1:0] s2_sep;
  logic [AC-1:0][OC-1:0][SQ_W-1:0]  s2_sq;

  ppcf_square_stage #(
    .INDEX_BITS   (INDEX_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_square (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (s1_valid),
    .up_ready       (s1_ready),
    .up_first_index (s1_first_index),
    .up_second_index(s1_second_index),
    .up_sep         (s1_sep),
    .dn_valid       (s2_valid),
    .dn_ready       (s2_ready),
    .first_index    (s2_first_index),
    .second_index   (s2_second_index),
    .sep            (s2_sep),
    .sq             (s2_sq)
  );

  // Stage 3: 27 sums against the cutoff
  logic s3_valid;
  logic s3_ready;
  logic [INDEX_BITS-1:0] s3_first_index;
  logic [INDEX_BITS-1:0] s3_second_index;
  logic [AC-1:0][OC-1:0][SEP_W-1:0] s3_sep;
  logic [ppcf_pkg::IMAGE_COUNT-1:0] s3_hit_mask;

  ppcf_cutoff_stage #(
    .INDEX_BITS   (INDEX_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_cutoff (
    .clk            (clk),
    .rst            (rst),
    .cutoff_sq      (cutoff_sq),
    .up_valid       (s2_valid),
    .up_ready       (s2_ready),
    .up_first_index (s2_first_index),
    .up_second_index(s2_second_index),
    .up_sep         (s2_sep),
    .up_sq          (s2_sq),
    .dn_valid       (s3_valid),
    .dn_ready       (s3_ready),
    .first_index    (s3_first_index),
    .second_index   (s3_second_index),
    .sep            (s3_sep),
    .hit_mask       (s3_hit_mask)
  );

  // Stage 4: drop empty masks, emit hits in image order
  ppcf_serializer #(
    .INDEX_BITS   (INDEX_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_serializer (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (s3_valid),
    .up_ready       (s3_ready),
    .up_first_index (s3_first_index),
    .up_second_index(s3_second_index),
    .up_sep         (s3_sep),
    .up_hit_mask    (s3_hit_mask),
    .hits           (hits)
  );

  // A hit taken that is not the last of its pair
  logic hit_more;
  assign hit_more = hits.valid && hits.ready && !hits.last;

  // A hit that is not the last of its pair is followed at once by the next one.
  `ASSERT_NEXT(a_hits_contiguous, clk, rst, hit_more, hits.valid)
  // Within a pair the image codes strictly rise.
  `ASSERT_NEXT(a_image_order, clk, rst, hit_more, hits.image_number > $past(hits.image_number))
  // The input stalls only when every pipeline stage holds a pair.
  `ASSERT_SAME(a_stall_full, clk, rst, !pairs.ready, s1_valid && s2_valid && s3_valid)

endmodule

`default_nettype wire
